>>> sv/signed_integer_to_radix_digits_assert.svh
// Assertion macros shared by the radix digit converter.
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define SIRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define SIRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/sird_pkg.sv
// Types, constants and the symbol lookup for the radix digit converter.
package sird_pkg;

  // Width of the base_size register and of the divider remainder.
  localparam int unsigned BaseW = 5;
  // Width of the configuration data and index.
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 2;
  // Symbol index width for up to sixteen symbols.
  localparam int unsigned SymIdxW  = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_BASE_SIZE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DIGITS_LOW  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DIGITS_HIGH = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [BaseW-1:0]    BASE_SIZE_RST   = 5'd10;
  localparam logic [CfgDataW-1:0] DIGITS_LOW_RST  = 64'h3736353433323130;
  localparam logic [CfgDataW-1:0] DIGITS_HIGH_RST = 64'h4645444342413938;

  // Character codes.
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SIGN,
    ST_POP,
    ST_SHOW
  } sird_state_e;

  // Divider status towards the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } sird_div_stat_t;

  // Picks symbol idx out of the two alphabet words.
  function automatic logic [7:0] sym_at(input logic [CfgDataW-1:0] lo,
                                        input logic [CfgDataW-1:0] hi,
                                        input logic [SymIdxW-1:0]  idx);
    logic [CfgDataW-1:0] word;
    word = idx[SymIdxW-1] ? hi : lo;
    return word[{idx[SymIdxW-2:0], 3'b000} +: 8];
  endfunction

endpackage

>>> sv/sird_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, narrow remainder.
module sird_div #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [VALUE_BITS-1:0]          dividend_i,
  input  logic [sird_pkg::BaseW-1:0]     divisor_i,
  output logic [VALUE_BITS-1:0]          quotient_o,
  output logic [sird_pkg::BaseW-1:0]     remainder_o,
  output sird_pkg::sird_div_stat_t       stat_o
);

  localparam int unsigned CntW = $clog2(VALUE_BITS + 1);

  logic                         busy_q;
  logic                         done_q;
  logic [CntW-1:0]              cnt_q;
  logic [VALUE_BITS-1:0]        shift_q, shift_d;
  logic [sird_pkg::BaseW-1:0]   rem_q, rem_d;
  logic [sird_pkg::BaseW-1:0]   dvs_q;
  logic [sird_pkg::BaseW:0]     trial;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_q, shift_q[VALUE_BITS-1]};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d   = sird_pkg::BaseW'(trial - {1'b0, dvs_q});
      shift_d = {shift_q[VALUE_BITS-2:0], 1'b1};
    end else begin
      rem_d   = trial[sird_pkg::BaseW-1:0];
      shift_d = {shift_q[VALUE_BITS-2:0], 1'b0};
    end
  end

  // Step counter; done pulses for one cycle after the last step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(VALUE_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= dividend_i;
      rem_q   <= '0;
      dvs_q   <= divisor_i;
    end else if (busy_q) begin
      shift_q <= shift_d;
      rem_q   <= rem_d;
    end
  end

  assign quotient_o  = shift_q;
  assign remainder_o = rem_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

>>> sv/signed_integer_to_radix_digits.sv
// Top level: converts a signed integer into its text in a configurable radix.
//
// Input channel: value_i with in_valid_i / in_stall_o. One beat is one integer.
// Output channel: character_o and last_o with out_valid_o / out_stall_i. One
// beat is one character, most significant digit first, led by '-' for a
// negative value; last_o marks the final character of each value.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 base_size, 1 digits_low, 2 digits_high); other indexes are ignored.
// Per value, the block accepts it, checks the base_size symbols of the
// alphabet (one symbol a cycle against every later symbol in use), then
// finds each digit in the bit-serial divider, then sends each digit
// character through the digit stack.
// An invalid alphabet or radix drops the value with no beats.
// The block takes one value at a time; the next is accepted once the last
// character sits in the output register, even while that beat is stalled.
// A stalled output beat holds its character and flag until taken.
// Reset empties the output register, returns to idle and loads the default
// decimal alphabet.
module signed_integer_to_radix_digits #(
  parameter int unsigned MAX_BASE   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sird_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [sird_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [VALUE_BITS-1:0]      value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        character_o,
  output logic                              last_o
);

  localparam int unsigned DigW = (MAX_BASE > 1) ? $clog2(MAX_BASE) : 1;
  localparam int unsigned SpW  = $clog2(VALUE_BITS + 1);
  localparam int unsigned AdrW = $clog2(VALUE_BITS);

  // Configuration registers.
  logic [sird_pkg::BaseW-1:0]    base_size_q;
  logic [sird_pkg::CfgDataW-1:0] digits_low_q;
  logic [sird_pkg::CfgDataW-1:0] digits_high_q;

  // Sequencer state.
  sird_pkg::sird_state_e state_q, state_d;
  logic [DigW-1:0]       idx_q, idx_d;
  logic [SpW-1:0]        sp_q, sp_d;
  logic                  neg_q, neg_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;

  // Output register.
  logic       out_valid_q;
  logic [7:0] char_q;
  logic       last_q;
  logic       out_free;
  logic       out_load;
  logic [7:0] out_char_d;
  logic       out_last_d;

  // Digit stack.
  logic [DigW-1:0] stack_mem [VALUE_BITS];
  logic [DigW-1:0] rd_q;
  logic            push;
  logic            pop;
  logic [SpW-1:0]  sp_m1;

  // Divider connections.
  logic                         div_start;
  logic [VALUE_BITS-1:0]        div_quot;
  logic [sird_pkg::BaseW-1:0]   div_rem;
  sird_pkg::sird_div_stat_t     div_stat;

  // Alphabet checks and input magnitude.
  logic                  base_ok;
  logic                  idx_last;
  logic [7:0]            sym_cur;
  logic                  sym_dup;
  logic                  sym_bad;
  logic [VALUE_BITS-1:0] value_u;
  logic [VALUE_BITS-1:0] mag_in;

  // Configuration writes; unknown indexes fall through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_size_q   <= sird_pkg::BASE_SIZE_RST;
      digits_low_q  <= sird_pkg::DIGITS_LOW_RST;
      digits_high_q <= sird_pkg::DIGITS_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sird_pkg::REG_BASE_SIZE:   base_size_q   <= cfg_data_i[sird_pkg::BaseW-1:0];
        sird_pkg::REG_DIGITS_LOW:  digits_low_q  <= cfg_data_i;
        sird_pkg::REG_DIGITS_HIGH: digits_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Radix range and the per-symbol check for the symbol under test.
  assign base_ok  = (base_size_q >= sird_pkg::BaseW'(2)) &&
                    (base_size_q <= sird_pkg::BaseW'(MAX_BASE));
  assign idx_last = (sird_pkg::BaseW'(idx_q) == base_size_q - sird_pkg::BaseW'(1));
  assign sym_cur  = sird_pkg::sym_at(digits_low_q, digits_high_q,
                                     sird_pkg::SymIdxW'(idx_q));

  // Compare the symbol under test with every later symbol in use.
  always_comb begin
    sym_dup = 1'b0;
    for (int j = 0; j < MAX_BASE; j++) begin
      if ((sird_pkg::BaseW'(j) > sird_pkg::BaseW'(idx_q)) &&
          (sird_pkg::BaseW'(j) < base_size_q) &&
          (sird_pkg::sym_at(digits_low_q, digits_high_q,
                            sird_pkg::SymIdxW'(j)) == sym_cur)) begin
        sym_dup = 1'b1;
      end
    end
  end

  assign sym_bad = sym_dup || (sym_cur == sird_pkg::CHAR_PLUS) ||
                   (sym_cur == sird_pkg::CHAR_MINUS) || (sym_cur == sird_pkg::CHAR_NUL);

  // Magnitude of the incoming value; the most negative value wraps to itself.
  assign value_u = value_i;
  assign mag_in  = value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;

  assign out_free = !out_valid_q || !out_stall_i;
  assign sp_m1    = sp_q - SpW'(1);

  // Next state and datapath controls.
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    sp_d       = sp_q;
    neg_d      = neg_q;
    mag_d      = mag_q;
    div_start  = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    out_load   = 1'b0;
    out_char_d = char_q;
    out_last_d = last_q;
    unique case (state_q)
      sird_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          neg_d = value_u[VALUE_BITS-1];
          mag_d = mag_in;
          idx_d = '0;
          sp_d  = '0;
          if (base_ok) begin
            state_d = sird_pkg::ST_CHECK;
          end
        end
      end
      sird_pkg::ST_CHECK: begin
        if (sym_bad) begin
          state_d = sird_pkg::ST_IDLE;
        end else if (idx_last) begin
          state_d = sird_pkg::ST_DIV_GO;
        end else begin
          idx_d = idx_q + DigW'(1);
        end
      end
      sird_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = sird_pkg::ST_DIV_WAIT;
      end
      sird_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          push  = 1'b1;
          sp_d  = sp_q + SpW'(1);
          mag_d = div_quot;
          if (div_quot == '0) begin
            state_d = neg_q ? sird_pkg::ST_SIGN : sird_pkg::ST_POP;
          end else begin
            state_d = sird_pkg::ST_DIV_GO;
          end
        end
      end
      sird_pkg::ST_SIGN: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_char_d = sird_pkg::CHAR_MINUS;
          out_last_d = 1'b0;
          state_d    = sird_pkg::ST_POP;
        end
      end
      sird_pkg::ST_POP: begin
        pop     = 1'b1;
        sp_d    = sp_m1;
        state_d = sird_pkg::ST_SHOW;
      end
      sird_pkg::ST_SHOW: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_char_d = sird_pkg::sym_at(digits_low_q, digits_high_q,
                                        sird_pkg::SymIdxW'(rd_q));
          out_last_d = (sp_q == '0);
          state_d    = (sp_q == '0) ? sird_pkg::ST_IDLE : sird_pkg::ST_POP;
        end
      end
      default: state_d = sird_pkg::ST_IDLE;
    endcase
  end

  // Sequencer and output control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sird_pkg::ST_IDLE;
      idx_q       <= '0;
      sp_q        <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      sp_q    <= sp_d;
      neg_q   <= neg_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    if (out_load) begin
      char_q <= out_char_d;
      last_q <= out_last_d;
    end
  end

  // Digit stack: least significant digit pushed first, popped last.
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[sp_q[AdrW-1:0]] <= div_rem[DigW-1:0];
    end
    if (pop) begin
      rd_q <= stack_mem[sp_m1[AdrW-1:0]];
    end
  end

  sird_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (mag_q),
    .divisor_i   (base_size_q),
    .quotient_o  (div_quot),
    .remainder_o (div_rem),
    .stat_o      (div_stat)
  );

  assign in_stall_o  = (state_q != sird_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  // Checks on the sequencer and divider hand-off.
  `include "signed_integer_to_radix_digits_assert.svh"

  `SIRD_ASSERT_NOW(a_sp_bound, 1'b1, sp_q <= SpW'(VALUE_BITS), "digit stack overflow")
  `SIRD_ASSERT_NOW(a_div_done_wait, div_stat.done, state_q == sird_pkg::ST_DIV_WAIT,
                   "divider finished outside the wait state")
  `SIRD_ASSERT_NOW(a_div_start_idle, div_start, !div_stat.busy,
                   "divider restarted while busy")
  `SIRD_ASSERT_NEXT(a_last_to_idle, out_load && out_last_d,
                    state_q == sird_pkg::ST_IDLE, "final beat loaded without returning idle")

endmodule
